// ===== hdl/gmft_pkg.sv =====
// shared widths and constants for the geared motor feedback tracker
// no dependencies; used by gmft_div, gmft_track and the top level
package gmft_pkg;

  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int CURRENT_W  = 16;
  localparam int RATIO_W    = 13;
  localparam int TURN_W     = 13;
  localparam int SHAFT_W    = 17;
  localparam int POS_W      = 32;
  localparam int THR_W      = 12;
  localparam int DIVIDEND_W = 16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 128;

  localparam int THR_NUMERATOR   = 4095;
  localparam int SHAFT_NUMERATOR = 8191;
  localparam int HALF_COUNT      = 4095;
  localparam int FULL_COUNT      = 8192;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1);

endpackage

// ===== hdl/gmft_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on gmft_pkg for the dividend and divisor widths
module gmft_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [gmft_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [gmft_pkg::RATIO_W-1:0]        divisor,
  output logic                                done,
  output logic [gmft_pkg::DIVIDEND_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(gmft_pkg::DIVIDEND_W + 1);

  logic                               busy;
  logic [CNT_W-1:0]                   count;
  logic [gmft_pkg::DIVIDEND_W-1:0]    q;
  logic [gmft_pkg::RATIO_W-1:0]       rem;
  logic [gmft_pkg::RATIO_W:0]         rem_shift;
  logic                               fits;

  assign rem_shift = {rem, q[gmft_pkg::DIVIDEND_W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign quotient  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(gmft_pkg::DIVIDEND_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= gmft_pkg::RATIO_W'(rem_shift - {1'b0, divisor});
      end else begin
        rem <= rem_shift[gmft_pkg::RATIO_W-1:0];
      end
      q <= {q[gmft_pkg::DIVIDEND_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/gmft_track.sv =====
// turn counting, shaft angle and relative position tracking over the steps go, stage1 and stage2
// depends on gmft_pkg; holds all per-frame tracking state
module gmft_track (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [gmft_pkg::ANGLE_W-1:0]      rotor,
  input  logic [gmft_pkg::THR_W-1:0]        thr,
  input  logic [gmft_pkg::TURN_W-1:0]       k,
  input  logic [gmft_pkg::RATIO_W-1:0]      ratio,
  output logic                              done,
  output logic [gmft_pkg::TURN_W-1:0]       turn_index,
  output logic [gmft_pkg::SHAFT_W-1:0]      shaft_angle,
  output logic [gmft_pkg::POS_W-1:0]        relative_position
);

  localparam int PROD_W = 2 * gmft_pkg::TURN_W;
  localparam int CNT_W  = gmft_pkg::TURN_W + 2;
  localparam int DS_W   = gmft_pkg::SHAFT_W + 1;

  logic                              stage1;
  logic                              stage2;
  logic                              seen_first_frame;
  logic [gmft_pkg::ANGLE_W-1:0]      prev_rotor_angle;
  logic [gmft_pkg::SHAFT_W-1:0]      prev_shaft_angle;
  logic [gmft_pkg::TURN_W-1:0]       turn_count;
  logic [gmft_pkg::POS_W-1:0]        position_accumulator;
  logic [PROD_W-1:0]                 prod;

  logic signed [gmft_pkg::ANGLE_W:0] d;
  logic signed [gmft_pkg::ANGLE_W:0] thr_s;
  logic signed [CNT_W-1:0]           cnt_step;
  logic [gmft_pkg::TURN_W-1:0]       turn_count_next;
  logic [gmft_pkg::SHAFT_W-1:0]      shaft;
  logic signed [DS_W-1:0]            ds;
  logic signed [DS_W-1:0]            adj;

  assign turn_index        = turn_count;
  assign shaft_angle       = prev_shaft_angle;
  assign relative_position = position_accumulator;

  always_comb begin
    d     = $signed({1'b0, rotor}) - $signed({1'b0, prev_rotor_angle});
    thr_s = $signed({{(gmft_pkg::ANGLE_W + 1 - gmft_pkg::THR_W){1'b0}}, thr});
    cnt_step = $signed({2'b00, turn_count});
    if (d > thr_s) begin
      cnt_step = cnt_step - CNT_W'(1);
    end else if (d < -thr_s) begin
      cnt_step = cnt_step + CNT_W'(1);
    end
    if (cnt_step >= $signed({2'b00, ratio})) begin
      turn_count_next = '0;
    end else if (cnt_step < 0) begin
      turn_count_next = ratio - gmft_pkg::TURN_W'(1);
    end else begin
      turn_count_next = cnt_step[gmft_pkg::TURN_W-1:0];
    end
  end

  always_comb begin
    shaft = prod[gmft_pkg::SHAFT_W-1:0] + {1'b0, rotor};
    ds    = $signed({1'b0, shaft}) - $signed({1'b0, prev_shaft_angle});
    if (ds > $signed(DS_W'(gmft_pkg::HALF_COUNT))) begin
      adj = ds - $signed(DS_W'(gmft_pkg::FULL_COUNT));
    end else if (ds < -$signed(DS_W'(gmft_pkg::HALF_COUNT))) begin
      adj = ds + $signed(DS_W'(gmft_pkg::FULL_COUNT));
    end else begin
      adj = ds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1               <= 1'b0;
      stage2               <= 1'b0;
      done                 <= 1'b0;
      seen_first_frame     <= 1'b0;
      prev_rotor_angle     <= '0;
      prev_shaft_angle     <= '0;
      turn_count           <= '0;
      position_accumulator <= '0;
    end else begin
      stage1 <= go;
      stage2 <= stage1;
      done   <= stage2;
      if (go) begin
        turn_count       <= turn_count_next;
        prev_rotor_angle <= rotor;
      end
      if (stage2) begin
        prev_shaft_angle <= shaft;
        seen_first_frame <= 1'b1;
        if (seen_first_frame) begin
          position_accumulator <= position_accumulator
                                  + {{(gmft_pkg::POS_W - DS_W){adj[DS_W-1]}}, adj};
        end else begin
          position_accumulator <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage1) begin
      prod <= turn_count * k;
    end
  end

endmodule

// ===== hdl/geared_motor_feedback_tracker.sv =====
// top level: frame sequencer, shared serial divider, tracker and output register
// depends on gmft_pkg, gmft_div and gmft_track
//
// usage
//   s_t* carries one motor feedback frame per transaction; m_t* carries one
//   result per frame; cfg_* writes the gear ratio (zero is taken as one)
//   the block works on one frame at a time: s_tready is high only while idle
//   and no ratio write is offered; a ratio write wins over a frame
//   a frame runs from acceptance to m_tvalid through two divider passes
//   (start, load, 16 quotient bits each), the tracking steps go, stage1 and
//   stage2, and the hold state that hands over to the output register
//   a ratio write keeps s_tready low while two divider passes
//   form the turn threshold and the per-turn shaft step
//   the result sits in an output register; a new frame is accepted while it
//   waits, and a finished frame waits for the register to empty when the
//   receiver stalls
//   reset (rst, synchronous) sets the ratio to one with its constants
//   preloaded, clears the tracking state and empties the output register
module geared_motor_feedback_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // angle_raw[15:0], speed_raw[31:16], current_raw[47:32]
  input  logic [gmft_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // rotor_speed[15:0], shaft_speed[31:16], scaled_rotor_angle[47:32],
  // turn_index[60:48], shaft_angle[77:61], relative_position[109:78],
  // motor_current[125:110], zero[127:126]
  output logic [gmft_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gmft_pkg::RATIO_W-1:0]       cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CONST_A = 7'b0000010,
    S_CONST_B = 7'b0000100,
    S_DIV_SPD = 7'b0001000,
    S_DIV_ANG = 7'b0010000,
    S_TRACK   = 7'b0100000,
    S_HOLD    = 7'b1000000
  } state_t;

  localparam int SP_W  = gmft_pkg::SPEED_W;
  localparam int DV_W  = gmft_pkg::DIVIDEND_W;
  localparam int PAD_W = gmft_pkg::OUT_DATA_W - 3 * SP_W - gmft_pkg::TURN_W
                         - gmft_pkg::SHAFT_W - gmft_pkg::POS_W - gmft_pkg::CURRENT_W;

  state_t                             state;
  logic [gmft_pkg::RATIO_W-1:0]       ratio;
  logic [gmft_pkg::THR_W-1:0]         thr;
  logic [gmft_pkg::TURN_W-1:0]        k;
  logic                               div_start;
  logic [DV_W-1:0]                    div_dividend;
  logic                               div_done;
  logic [DV_W-1:0]                    div_quotient;
  logic                               track_go;
  logic                               track_done;
  logic [gmft_pkg::TURN_W-1:0]        turn_index;
  logic [gmft_pkg::SHAFT_W-1:0]       shaft_angle;
  logic [gmft_pkg::POS_W-1:0]         relative_position;

  logic [gmft_pkg::ANGLE_W-1:0]       angle_hold;
  logic [SP_W-1:0]                    speed_hold;
  logic [gmft_pkg::CURRENT_W-1:0]     current_hold;
  logic [SP_W-1:0]                    shaft_speed;
  logic [gmft_pkg::ANGLE_W-1:0]       rotor;
  logic [SP_W-1:0]                    speed_in;
  logic [SP_W-1:0]                    speed_mag;
  logic                               out_free;

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign speed_in  = s_tdata[2*SP_W-1:SP_W];
  assign speed_mag = speed_in[SP_W-1] ? SP_W'(~speed_in + SP_W'(1)) : speed_in;

  gmft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ratio),
    .done     (div_done),
    .quotient (div_quotient)
  );

  gmft_track u_track (
    .clk               (clk),
    .rst               (rst),
    .go                (track_go),
    .rotor             (rotor),
    .thr               (thr),
    .k                 (k),
    .ratio             (ratio),
    .done              (track_done),
    .turn_index        (turn_index),
    .shaft_angle       (shaft_angle),
    .relative_position (relative_position)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ratio     <= gmft_pkg::RATIO_RESET;
      thr       <= gmft_pkg::THR_W'(gmft_pkg::THR_NUMERATOR);
      k         <= gmft_pkg::TURN_W'(gmft_pkg::SHAFT_NUMERATOR);
      div_start <= 1'b0;
      track_go  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      track_go  <= 1'b0;
      if ((state == S_HOLD) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            ratio     <= (cfg_data == '0) ? gmft_pkg::RATIO_RESET : cfg_data;
            div_start <= 1'b1;
            state     <= S_CONST_A;
          end else if (s_tvalid) begin
            div_start <= 1'b1;
            state     <= S_DIV_SPD;
          end
        end
        S_CONST_A: begin
          if (div_done) begin
            thr       <= div_quotient[gmft_pkg::THR_W-1:0];
            div_start <= 1'b1;
            state     <= S_CONST_B;
          end
        end
        S_CONST_B: begin
          if (div_done) begin
            k     <= div_quotient[gmft_pkg::TURN_W-1:0];
            state <= S_IDLE;
          end
        end
        S_DIV_SPD: begin
          if (div_done) begin
            div_start <= 1'b1;
            state     <= S_DIV_ANG;
          end
        end
        S_DIV_ANG: begin
          if (div_done) begin
            track_go <= 1'b1;
            state    <= S_TRACK;
          end
        end
        S_TRACK: begin
          if (track_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          div_dividend <= DV_W'(gmft_pkg::THR_NUMERATOR);
        end else if (s_tvalid) begin
          angle_hold   <= s_tdata[gmft_pkg::ANGLE_W-1:0];
          speed_hold   <= speed_in;
          current_hold <= s_tdata[3*SP_W-1:2*SP_W];
          div_dividend <= speed_mag;
        end
      end
      S_CONST_A: begin
        div_dividend <= DV_W'(gmft_pkg::SHAFT_NUMERATOR);
      end
      S_DIV_SPD: begin
        if (div_done) begin
          shaft_speed  <= speed_hold[SP_W-1] ? SP_W'(~div_quotient + SP_W'(1))
                                             : div_quotient;
          div_dividend <= angle_hold;
        end
      end
      S_DIV_ANG: begin
        if (div_done) begin
          rotor <= div_quotient;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          m_tdata <= {{PAD_W{1'b0}}, current_hold, relative_position, shaft_angle,
                      turn_index, rotor, shaft_speed, speed_hold};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
